// ----- src/ipc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, constants and ones-complement helpers of the checksum engine.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
  localparam logic [5:0]  IPV6_HDR_LEN     = 6'd40;
  localparam logic [15:0] TCP_PROTO        = 16'd6;
  localparam logic [15:0] MIN_TAIL_BYTES   = 16'd18;

  localparam logic [15:0] V4_LEN_HI     = 16'd2;
  localparam logic [15:0] V4_LEN_LO     = 16'd3;
  localparam logic [15:0] V6_LEN_HI     = 16'd4;
  localparam logic [15:0] V6_LEN_LO     = 16'd5;
  localparam logic [15:0] V4_HCK_HI     = 16'd10;
  localparam logic [15:0] V4_HCK_LO     = 16'd11;
  localparam logic [15:0] V4_ADDR_FIRST = 16'd12;
  localparam logic [15:0] V4_ADDR_LAST  = 16'd19;
  localparam logic [15:0] V6_ADDR_FIRST = 16'd8;
  localparam logic [15:0] V6_ADDR_LAST  = 16'd39;
  localparam logic [15:0] TCP_CK_HI     = 16'd16;
  localparam logic [15:0] TCP_CK_LO     = 16'd17;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] hl;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic [31:0] seg_sum;
    logic [20:0] hdr_sum;
    logic [15:0] length;
    logic [15:0] seen_seg;
    logic [15:0] seen_hdr;
    logic        short_pkt;
    logic [5:0]  hl;
    logic        v6;
  } fin_t;

  typedef struct packed {
    logic [31:0] seg;
    logic [20:0] hdr_sum;
    logic [15:0] seen_seg;
    logic [15:0] seen_hdr;
    logic        short_pkt;
    logic        v6;
  } sum_t;

  typedef struct packed {
    logic [15:0] tcp_checksum;
    logic        tcp_checksum_matches;
    logic [15:0] header_checksum;
    logic        header_checksum_matches;
    logic        too_short;
  } result_t;

  function automatic logic [15:0] weigh(input logic odd, input logic [7:0] b);
    return odd ? {8'h00, b} : {b, 8'h00};
  endfunction

  // end-around carry of a sum of a 32-bit value and small addends
  function automatic logic [31:0] fold32(input logic [33:0] t);
    return 32'(t[31:0] + {30'd0, t[33:32]});
  endfunction

  function automatic logic [20:0] add21(input logic [20:0] acc, input logic [15:0] v);
    logic [21:0] s;
    s = {1'b0, acc} + {6'd0, v};
    return 21'(s[20:0] + {20'd0, s[21]});
  endfunction

  function automatic logic [15:0] finish16(input logic [31:0] s);
    logic [16:0] t1;
    logic [16:0] t2;
    logic [16:0] t3;
    t1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    t2 = {1'b0, t1[15:0]} + {16'd0, t1[16]};
    t3 = {1'b0, t2[15:0]} + {16'd0, t2[16]};
    return ~t3[15:0];
  endfunction

endpackage

// ----- src/ipc_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_accum
// Per-packet running sums and captured fields, one byte per cycle; a last byte
// waits on a full hand-off register, moves the totals there and clears state.
// ----------------------------------------------------------------------------
module ipc_accum (
  input  logic           clk,
  input  logic           rst,
  input  logic           v6,
  input  logic           item_valid,
  output logic           item_ready,
  input  ipc_pkg::byte_t item,
  output logic           fin_valid,
  input  logic           fin_ready,
  output ipc_pkg::fin_t  fin
);

  logic [15:0] position;
  logic [31:0] segment_sum;
  logic [20:0] header_sum;
  logic [15:0] length_field;
  logic [15:0] seen_segment_checksum;
  logic [15:0] seen_header_checksum;

  logic [15:0] position_next;
  logic [31:0] segment_sum_next;
  logic [20:0] header_sum_next;
  logic [15:0] length_field_next;
  logic [15:0] seen_segment_checksum_next;
  logic [15:0] seen_header_checksum_next;

  logic [15:0] hl16;
  logic [15:0] seg_ofs;
  logic [15:0] wp;
  logic [15:0] addr_add;
  logic [15:0] seg_add;
  logic        active;
  logic        in_hdr;
  logic        is_hck;
  logic        is_len;
  logic        is_addr;
  logic        in_seg;
  logic        is_sck;
  logic        fire;
  logic        fin_load_ok;

  assign hl16    = {10'd0, item.hl};
  assign seg_ofs = position - hl16;
  assign wp      = ipc_pkg::weigh(position[0], item.data);
  assign active  = position != ipc_pkg::MAX_PACKET_BYTES;

  assign in_hdr = !v6 && (position < hl16);
  assign is_hck = !v6 && (position == ipc_pkg::V4_HCK_HI || position == ipc_pkg::V4_HCK_LO);
  assign is_len = v6 ? (position == ipc_pkg::V6_LEN_HI || position == ipc_pkg::V6_LEN_LO)
                     : (position == ipc_pkg::V4_LEN_HI || position == ipc_pkg::V4_LEN_LO);
  assign is_addr = v6 ? (position >= ipc_pkg::V6_ADDR_FIRST && position <= ipc_pkg::V6_ADDR_LAST)
                      : (position >= ipc_pkg::V4_ADDR_FIRST && position <= ipc_pkg::V4_ADDR_LAST);
  assign in_seg = position >= hl16;
  assign is_sck = in_seg && (seg_ofs == ipc_pkg::TCP_CK_HI || seg_ofs == ipc_pkg::TCP_CK_LO);

  assign addr_add = is_addr ? wp : 16'd0;
  assign seg_add  = (in_seg && !is_sck) ? ipc_pkg::weigh(seg_ofs[0], item.data) : 16'd0;

  always_comb begin
    position_next              = position;
    segment_sum_next           = segment_sum;
    header_sum_next            = header_sum;
    length_field_next          = length_field;
    seen_segment_checksum_next = seen_segment_checksum;
    seen_header_checksum_next  = seen_header_checksum;
    if (active) begin
      position_next    = position + 16'd1;
      segment_sum_next = ipc_pkg::fold32({2'b00, segment_sum} + {18'd0, addr_add}
                                         + {18'd0, seg_add});
      if (is_hck) begin
        seen_header_checksum_next = {seen_header_checksum[7:0], item.data};
      end else if (in_hdr) begin
        header_sum_next = ipc_pkg::add21(header_sum, wp);
      end
      if (is_len) begin
        length_field_next = {length_field[7:0], item.data};
      end
      if (is_sck) begin
        seen_segment_checksum_next = {seen_segment_checksum[7:0], item.data};
      end
    end
  end

  assign fin_load_ok = !fin_valid || fin_ready;
  assign item_ready  = !item.last || fin_load_ok;
  assign fire        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position              <= '0;
      segment_sum           <= '0;
      header_sum            <= '0;
      length_field          <= '0;
      seen_segment_checksum <= '0;
      seen_header_checksum  <= '0;
    end else if (fire) begin
      if (item.last) begin
        position              <= '0;
        segment_sum           <= '0;
        header_sum            <= '0;
        length_field          <= '0;
        seen_segment_checksum <= '0;
        seen_header_checksum  <= '0;
      end else begin
        position              <= position_next;
        segment_sum           <= segment_sum_next;
        header_sum            <= header_sum_next;
        length_field          <= length_field_next;
        seen_segment_checksum <= seen_segment_checksum_next;
        seen_header_checksum  <= seen_header_checksum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fire && item.last) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.last) begin
      fin.seg_sum   <= segment_sum_next;
      fin.hdr_sum   <= header_sum_next;
      fin.length    <= length_field_next;
      fin.seen_seg  <= seen_segment_checksum_next;
      fin.seen_hdr  <= seen_header_checksum_next;
      fin.short_pkt <= position_next < (hl16 + ipc_pkg::MIN_TAIL_BYTES);
      fin.hl        <= item.hl;
      fin.v6        <= v6;
    end
  end

endmodule

// ----- src/ipc_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_finish
// Adds the pseudo-header protocol and length terms, then folds, complements
// and compares both checksums into the result register (header one IPv4 only).
// ----------------------------------------------------------------------------
module ipc_finish (
  input  logic             clk,
  input  logic             rst,
  input  logic             fin_valid,
  output logic             fin_ready,
  input  ipc_pkg::fin_t    fin,
  output logic             res_valid,
  input  logic             res_ready,
  output ipc_pkg::result_t res
);

  logic          sum_valid;
  ipc_pkg::sum_t sum;
  logic          sum_adv;
  logic [15:0]   len_term;
  logic [15:0]   tcp;
  logic [15:0]   hdr;

  assign len_term  = fin.v6 ? fin.length : fin.length - {10'd0, fin.hl};
  assign sum_adv   = !res_valid || res_ready;
  assign fin_ready = !sum_valid || sum_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (fin_ready) begin
      sum_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      sum.seg       <= ipc_pkg::fold32({2'b00, fin.seg_sum} + {18'd0, ipc_pkg::TCP_PROTO}
                                       + {18'd0, len_term});
      sum.hdr_sum   <= fin.hdr_sum;
      sum.seen_seg  <= fin.seen_seg;
      sum.seen_hdr  <= fin.seen_hdr;
      sum.short_pkt <= fin.short_pkt;
      sum.v6        <= fin.v6;
    end
  end

  assign tcp = ipc_pkg::finish16(sum.seg);
  assign hdr = sum.v6 ? 16'd0 : ipc_pkg::finish16({11'd0, sum.hdr_sum});

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sum_adv) begin
      res_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_adv && sum_valid) begin
      res.tcp_checksum            <= tcp;
      res.tcp_checksum_matches    <= !sum.short_pkt && (tcp == sum.seen_seg);
      res.header_checksum         <= hdr;
      res.header_checksum_matches <= sum.v6 || (!sum.short_pkt && (hdr == sum.seen_hdr));
      res.too_short               <= sum.short_pkt;
    end
  end

endmodule

// ----- src/tcp_ip_checksum_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_ip_checksum_engine
// TCP checksum over pseudo header and segment, plus IPv4 header checksum,
// for IPv4 or IPv6 packets fed one byte per word.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_ready    data_byte, header_length, last_byte
//   out      from block out_valid / out_ready  tcp_checksum, tcp_checksum_matches,
//                                              header_checksum,
//                                              header_checksum_matches, too_short
//   cfg      to block   cfg_valid / cfg_ready  cfg_data (ip_version_six)
//
// one byte word per cycle, unless a last byte waits on a full sum hand-off;
// every byte only updates running sums and captured fields; a result passes
// through the input register, sum hand-off, pseudo-header add and result
// register to out_valid; these let up to four packets be in flight;
// out_ready low stalls back to in_ready only once all of them are full
// synchronous reset clears valids, packet state and ip_version_six
// ----------------------------------------------------------------------------
module tcp_ip_checksum_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  header_length,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tcp_checksum,
  output logic        tcp_checksum_matches,
  output logic [15:0] header_checksum,
  output logic        header_checksum_matches,
  output logic        too_short,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic             ip_version_six;
  logic             item_valid;
  logic             item_ready;
  ipc_pkg::byte_t   item;
  logic             fin_valid;
  logic             fin_ready;
  ipc_pkg::fin_t    fin;
  ipc_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ip_version_six <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ip_version_six <= cfg_data;
    end
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.data <= data_byte;
      item.hl   <= ip_version_six ? ipc_pkg::IPV6_HDR_LEN : header_length;
      item.last <= last_byte;
    end
  end

  ipc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .v6         (ip_version_six),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin        (fin)
  );

  ipc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign tcp_checksum            = res.tcp_checksum;
  assign tcp_checksum_matches    = res.tcp_checksum_matches;
  assign header_checksum         = res.header_checksum;
  assign header_checksum_matches = res.header_checksum_matches;
  assign too_short               = res.too_short;

endmodule

// ----- src/ipc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the checksum engine, bound to the top level.
// ----------------------------------------------------------------------------
module ipc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tcp_checksum,
  input logic        tcp_checksum_matches,
  input logic [15:0] header_checksum,
  input logic        header_checksum_matches,
  input logic        too_short,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_data
);

  logic [2:0] pending;
  logic       v6_seen;

  // packets whose last word went in and whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'd0, in_valid && in_ready && last_byte}
                         - {2'd0, out_valid && out_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6_seen <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      v6_seen <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tcp_checksum)
      && $stable(header_checksum) && $stable(too_short))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a finished packet");

  a_v6_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && v6_seen |-> header_checksum == 16'd0 && header_checksum_matches)
    else $error("header checksum reported in ipv6 mode");

  a_short_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> !tcp_checksum_matches)
    else $error("short packet flagged as matching");

endmodule

bind tcp_ip_checksum_engine ipc_checker u_ipc_checker (
  .clk                     (clk),
  .rst                     (rst),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .last_byte               (last_byte),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .tcp_checksum            (tcp_checksum),
  .tcp_checksum_matches    (tcp_checksum_matches),
  .header_checksum         (header_checksum),
  .header_checksum_matches (header_checksum_matches),
  .too_short               (too_short),
  .cfg_valid               (cfg_valid),
  .cfg_ready               (cfg_ready),
  .cfg_data                (cfg_data)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for tcp_ip_checksum_engine. Feeds IPv4 and IPv6 packets one byte
// word at a time, under random sender and receiver idling and a long receiver
// stall. Each accepted byte is run through a local copy of the checksum
// logic, and every result word leaving the block is checked field by field
// against the oldest one due.
// ----------------------------------------------------------------------------

class packet_checksummer;
  logic        ip6;
  logic [15:0] pos;
  logic [31:0] seg_acc;
  logic [20:0] hdr_acc;
  logic [15:0] len_field;
  logic [15:0] got_seg_ck;
  logic [15:0] got_hdr_ck;
  ipc_pkg::result_t checksums_due[$];
  int          mismatches;

  function new();
    ip6 = 1'b0;
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    pos = '0;
    seg_acc = '0;
    hdr_acc = '0;
    len_field = '0;
    got_seg_ck = '0;
    got_hdr_ck = '0;
  endfunction

  function logic [31:0] acc32(logic [31:0] a, logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[31:0] + 32'(s[32]);
  endfunction

  function logic [20:0] acc21(logic [20:0] a, logic [15:0] v);
    logic [21:0] s;
    s = {1'b0, a} + 22'(v);
    return s[20:0] + 21'(s[21]);
  endfunction

  function logic [15:0] fold_invert(logic [31:0] s);
    logic [32:0] t;
    t = {1'b0, s};
    repeat (3) t = 33'(t[15:0]) + 33'(t[32:16]);
    return ~t[15:0];
  endfunction

  function logic [15:0] place(logic odd, logic [7:0] b);
    return odd ? {8'h00, b} : {b, 8'h00};
  endfunction

  // adds one byte to the running sums, returns 1 with the result on the last one
  function bit sum_byte(logic [7:0] b, logic [5:0] hl_in, logic lst,
                        output ipc_pkg::result_t r);
    logic [15:0] hl;
    logic [15:0] p;
    logic [15:0] k;
    logic [31:0] seg;
    logic        short_pkt;
    r = '0;
    hl = ip6 ? 16'(ipc_pkg::IPV6_HDR_LEN) : 16'(hl_in);
    if (pos < ipc_pkg::MAX_PACKET_BYTES) begin
      p = pos;
      if (!ip6) begin
        if (p == ipc_pkg::V4_HCK_HI || p == ipc_pkg::V4_HCK_LO)
          got_hdr_ck = {got_hdr_ck[7:0], b};
        else if (p < hl) hdr_acc = acc21(hdr_acc, place(p[0], b));
      end
      if ((!ip6 && (p == ipc_pkg::V4_LEN_HI || p == ipc_pkg::V4_LEN_LO)) ||
          (ip6 && (p == ipc_pkg::V6_LEN_HI || p == ipc_pkg::V6_LEN_LO)))
        len_field = {len_field[7:0], b};
      if ((!ip6 && p >= ipc_pkg::V4_ADDR_FIRST && p <= ipc_pkg::V4_ADDR_LAST) ||
          (ip6 && p >= ipc_pkg::V6_ADDR_FIRST && p <= ipc_pkg::V6_ADDR_LAST))
        seg_acc = acc32(seg_acc, 32'(place(p[0], b)));
      if (p >= hl) begin
        k = p - hl;
        if (k == ipc_pkg::TCP_CK_HI || k == ipc_pkg::TCP_CK_LO)
          got_seg_ck = {got_seg_ck[7:0], b};
        else seg_acc = acc32(seg_acc, 32'(place(k[0], b)));
      end
      pos = p + 16'd1;
    end
    if (!lst) return 1'b0;
    seg = acc32(seg_acc, 32'(ipc_pkg::TCP_PROTO));
    seg = acc32(seg, ip6 ? 32'(len_field) : 32'(16'(len_field - hl)));
    short_pkt = 32'(pos) < 32'(hl) + 32'(ipc_pkg::MIN_TAIL_BYTES);
    r.tcp_checksum = fold_invert(seg);
    r.tcp_checksum_matches = !short_pkt && r.tcp_checksum == got_seg_ck;
    r.header_checksum = ip6 ? 16'd0 : fold_invert(32'(hdr_acc));
    r.header_checksum_matches = ip6 ? 1'b1 :
                                (!short_pkt && r.header_checksum == got_hdr_ck);
    r.too_short = short_pkt;
    clear();
    return 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic [5:0] hl, logic lst);
    ipc_pkg::result_t r;
    if (sum_byte(b, hl, lst, r)) checksums_due.push_back(r);
  endfunction

  function void check_result(ipc_pkg::result_t got);
    ipc_pkg::result_t want;
    if (checksums_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: tcp %h/%b hdr %h/%b short %b",
                 got.tcp_checksum, got.tcp_checksum_matches, got.header_checksum,
                 got.header_checksum_matches, got.too_short);
      return;
    end
    want = checksums_due.pop_front();
    if (got.tcp_checksum !== want.tcp_checksum ||
        got.tcp_checksum_matches !== want.tcp_checksum_matches ||
        got.header_checksum !== want.header_checksum ||
        got.header_checksum_matches !== want.header_checksum_matches ||
        got.too_short !== want.too_short) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: tcp %h/%b hdr %h/%b short %b expected, ",
                  "tcp %h/%b hdr %h/%b short %b seen"},
                 want.tcp_checksum, want.tcp_checksum_matches, want.header_checksum,
                 want.header_checksum_matches, want.too_short,
                 got.tcp_checksum, got.tcp_checksum_matches, got.header_checksum,
                 got.header_checksum_matches, got.too_short);
    end
  endfunction
endclass

module tb;
  localparam int ITEMS        = 1150;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int STALL_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic [5:0]  header_length = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] tcp_checksum;
  logic        tcp_checksum_matches;
  logic [15:0] header_checksum;
  logic        header_checksum_matches;
  logic        too_short;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  packet_checksummer sums;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  int  stall_reqs = 0;
  int  stall_served = 0;
  int  stall_left = 0;
  int  sent_bytes = 0;
  int  seg_pkts;
  int  cycles = 0;

  tcp_ip_checksum_engine u_dut (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .data_byte               (data_byte),
    .header_length           (header_length),
    .last_byte               (last_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .tcp_checksum            (tcp_checksum),
    .tcp_checksum_matches    (tcp_checksum_matches),
    .header_checksum         (header_checksum),
    .header_checksum_matches (header_checksum_matches),
    .too_short               (too_short),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_data                (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random idling plus one long hold-off
  always @(negedge clk) begin
    if (stall_reqs != stall_served) begin
      stall_served = stall_reqs;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sums.check_result('{tcp_checksum, tcp_checksum_matches, header_checksum,
                          header_checksum_matches, too_short});
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL tcp_ip_checksum_engine");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic [5:0] hl, input logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    header_length <= hl;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    sums.note_byte(b, hl, lst);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] pkt[], input logic [5:0] hl, input bit vary);
    foreach (pkt[i])
      send_byte(pkt[i], vary ? 6'($urandom_range(63)) : hl, i == pkt.size() - 1);
    seg_pkts++;
  endtask

  // lets every expected word come back, then idles before returning
  task automatic drain();
    in_valid <= 1'b0;
    while (sums.checksums_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input logic six);
    cfg_valid <= 1'b1;
    cfg_data <= six;
    do @(posedge clk); while (!cfg_ready);
    sums.ip6 = six;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed packets with random content, the rest short or noise
  function automatic void build_packet(input logic six,
                                       output logic [7:0] pkt[], output logic [5:0] hl,
                                       output bit vary);
    packet_checksummer calc;
    ipc_pkg::result_t r;
    int kind;
    int n;
    int hlen;
    calc = new();
    calc.ip6 = six;
    vary = 1'b0;
    kind = $urandom_range(99);
    hl = six ? 6'($urandom_range(63)) : 6'($urandom_range(20, 60));
    hlen = six ? int'(ipc_pkg::IPV6_HDR_LEN) : int'(hl);
    if (kind < 60) n = hlen + $urandom_range(18, 48);
    else if (kind < 75) n = $urandom_range(1, hlen + 17);
    else if (kind < 90) begin
      hl = 6'($urandom_range(19));
      n = $urandom_range(1, 60);
    end else begin
      vary = 1'b1;
      n = $urandom_range(1, 90);
    end
    pkt = new[n];
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    if (kind < 60) begin
      if ($urandom_range(99) < 85) begin
        if (six) {pkt[4], pkt[5]} = 16'(n - hlen);
        else {pkt[2], pkt[3]} = 16'(n);
      end
      foreach (pkt[i]) void'(calc.sum_byte(pkt[i], hl, i == n - 1, r));
      if (!six && $urandom_range(99) < 80)
        {pkt[10], pkt[11]} = r.header_checksum;
      if ($urandom_range(99) < 80)
        {pkt[hlen + 16], pkt[hlen + 17]} = r.tcp_checksum;
    end
  endfunction

  initial begin
    logic [7:0] pkt[];
    logic [5:0] hl;
    bit         vary;
    logic       six;
    sums = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // extremes, header shorter than twenty with odd length, short packets
    send_byte(8'hFF, 6'd63, 1'b1);
    send_byte(8'h00, 6'd0, 1'b1);
    for (int i = 0; i < 21; i++)
      send_byte(i == 2 ? 8'h00 : i == 3 ? 8'd21 : 8'hFF, 6'd3, i == 20);
    drain();
    write_mode(1'b1);
    send_byte(8'hA5, 6'd0, 1'b1);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      six = seg inside {1, 2, 5};
      in_idle_pct = seg < 2 ? 22 : seg < 4 ? 79 : 0;
      out_idle_pct = seg < 2 ? 79 : seg < 4 ? 22 : 0;
      write_mode(six);
      seg_pkts = 0;
      if (seg == 4) begin
        stall_reqs++;
        for (int i = 0; i < 24; i++) begin
          pkt = new[$urandom_range(1, 3)];
          foreach (pkt[j]) pkt[j] = 8'($urandom);
          send_packet(pkt, 6'($urandom_range(20, 60)), 1'b0);
        end
      end
      while (sent_bytes < ITEMS * (seg + 1) / 6) begin
        build_packet(six, pkt, hl, vary);
        send_packet(pkt, hl, vary);
        if (seg == 2 && seg_pkts == 1) drain();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (sums.mismatches == 0 && sums.checksums_due.size() == 0) begin
      $display("PASS tcp_ip_checksum_engine");
    end else begin
      $display("FAIL tcp_ip_checksum_engine");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/ipc_pkg.sv
src/ipc_accum.sv
src/ipc_finish.sv
src/tcp_ip_checksum_engine.sv
src/ipc_checker.sv
sim/tb.sv
